// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the line editor rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TLEH_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tleh assertion failed");

// next-cycle implication
`define TLEH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tleh assertion failed");

`endif

// ----- rtl/core/tleh_pkg.sv -----
// types and constants of the line editor with history ring
package tleh_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 3;

   localparam logic [7:0] BYTE_INTR     = 8'h03;
   localparam logic [7:0] BYTE_BS       = 8'h08;
   localparam logic [7:0] BYTE_TAB      = 8'h09;
   localparam logic [7:0] BYTE_LF       = 8'h0A;
   localparam logic [7:0] BYTE_CR       = 8'h0D;
   localparam logic [7:0] BYTE_KILL     = 8'h15;
   localparam logic [7:0] BYTE_WORD     = 8'h17;
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] BYTE_NEWER    = 8'h2B;
   localparam logic [7:0] BYTE_OLDER    = 8'h5F;
   localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
   localparam logic [7:0] BYTE_DEL      = 8'h7F;

   typedef enum logic [KIND_W-1:0] {
      TK_ECHO    = 3'd0,
      TK_ERASE   = 3'd1,
      TK_BELL    = 3'd2,
      TK_NEWLINE = 3'd3,
      TK_CANCEL  = 3'd4,
      TK_LINE    = 3'd5
   } tleh_kind_type;

   typedef enum logic [3:0] {
      CLS_NONE   = 4'd0,
      CLS_ENTER  = 4'd1,
      CLS_BS     = 4'd2,
      CLS_OLDER  = 4'd3,
      CLS_NEWER  = 4'd4,
      CLS_KILL   = 4'd5,
      CLS_WORD   = 4'd6,
      CLS_CANCEL = 4'd7,
      CLS_PRINT  = 4'd8
   } tleh_class_type;

   typedef enum logic [1:0] {
      CH_ZERO = 2'd0,
      CH_BYTE = 2'd1,
      CH_EDIT = 2'd2,
      CH_HIST = 2'd3
   } tleh_chsel_type;

   typedef struct packed {
      logic           latch_byte;
      logic           emit;
      tleh_kind_type  kind;
      tleh_chsel_type ch_sel;
      logic           edit_wr;
      logic           edit_wr_hist;
      logic           cursor_inc;
      logic           cursor_dec;
      logic           clear_line;
      logic           idx_clr;
      logic           idx_inc;
      logic           browse_newest;
      logic           browse_dec;
      logic           browse_inc;
      logic           browsing_set;
      logic           browsing_clr;
      logic           limit_load;
      logic           edit_rd_tail;
      logic           hl_rd_browse;
      logic           hist_rd_browse;
      logic           hist_wr;
      logic           commit;
      logic           flush;
   } tleh_cmd_type;

   typedef struct packed {
      tleh_class_type cls;
      logic           cursor_zero;
      logic           cursor_full;
      logic           fill_zero;
      logic           browsing;
      logic           at_oldest;
      logic           at_newest;
      logic           idx_last_cursor;
      logic           idx_last_limit;
      logic           hl_eq_cursor;
      logic           cmp_eq;
      logic           tail_blank;
      logic           can_emit;
      logic           flush_ok;
      logic           hold_empty;
   } tleh_sts_type;

endpackage

// ----- rtl/core/tleh_chan_if.sv -----
// request and response channel interfaces of the line editor
interface tleh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface tleh_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [7:0] token_char;
   logic       last_of_run;
   modport source (output valid, output token_kind, output token_char, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input token_char, input last_of_run,
                 output ready);
endinterface

// ----- rtl/core/tleh_dp.sv -----
// datapath of the line editor: edit line, history ring, token hold and output stage
module tleh_dp #(
   parameter int LINE_LEN   = 32,
   parameter int HIST_DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             rx_byte,
   input  logic                   rsp_ready,
   input  tleh_pkg::tleh_cmd_type cmd,
   output tleh_pkg::tleh_sts_type sts,
   output logic                   rsp_valid,
   output logic [2:0]             token_kind,
   output logic [7:0]             token_char,
   output logic                   last_of_run
);
   import tleh_pkg::*;

   localparam int CUR_W  = $clog2(LINE_LEN);
   localparam int SLOT_W = $clog2(HIST_DEPTH);
   localparam int FILL_W = $clog2(HIST_DEPTH + 1);
   localparam int HA_W   = $clog2(HIST_DEPTH * LINE_LEN);
   localparam int OW     = SLOT_W + 2;

   logic [7:0]        byte_ff;
   logic [CUR_W-1:0]  cursor_ff, cursor_in, idx_ff, idx_in, limit_ff, limit_in;
   logic [SLOT_W-1:0] head_ff, head_in, browse_ff, browse_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              browsing_ff, browsing_in;
   logic              hold_v_ff, hold_v_in;
   tleh_kind_type     hold_kind_ff, hold_kind_in;
   logic [7:0]        hold_char_ff, hold_char_in;
   logic              out_v_ff, out_v_in, out_last_ff, out_last_in;
   tleh_kind_type     out_kind_ff, out_kind_in;
   logic [7:0]        out_char_ff, out_char_in;

   logic [7:0]        edit_mem [LINE_LEN];
   logic [7:0]        hist_mem [HIST_DEPTH * LINE_LEN];
   logic [CUR_W-1:0]  hl_mem [HIST_DEPTH];
   logic [7:0]        edit_rd_ff, hist_rd_ff;
   logic [CUR_W-1:0]  hl_rd_ff;

   logic [SLOT_W-1:0] newest, oldest, hist_slot, hl_raddr;
   logic [OW-1:0]     old_sum;
   logic [CUR_W-1:0]  edit_raddr;
   logic [HA_W-1:0]   hist_raddr, hist_waddr;
   logic [7:0]        emit_char, edit_wdata;
   logic              out_free;
   tleh_class_type    cls;

   assign newest  = (head_ff == '0) ? SLOT_W'(HIST_DEPTH - 1) : head_ff - 1'b1;
   assign old_sum = OW'(head_ff) + OW'(HIST_DEPTH) - OW'(fill_ff);
   assign oldest  = (old_sum >= OW'(HIST_DEPTH)) ? SLOT_W'(old_sum - OW'(HIST_DEPTH))
                                                 : SLOT_W'(old_sum);

   assign edit_raddr = cmd.edit_rd_tail ? cursor_ff - 1'b1 : idx_ff;
   assign hist_slot  = cmd.hist_rd_browse ? browse_ff : newest;
   assign hl_raddr   = cmd.hl_rd_browse ? browse_ff : newest;
   assign hist_raddr = HA_W'(hist_slot) * HA_W'(LINE_LEN) + HA_W'(idx_ff);
   assign hist_waddr = HA_W'(head_ff) * HA_W'(LINE_LEN) + HA_W'(idx_ff);
   assign edit_wdata = cmd.edit_wr_hist ? hist_rd_ff : byte_ff;

   // byte decode
   always_comb begin
      priority if (byte_ff == BYTE_CR || byte_ff == BYTE_LF) cls = CLS_ENTER;
      else if (byte_ff == BYTE_BS || byte_ff == BYTE_DEL)    cls = CLS_BS;
      else if (byte_ff == BYTE_TAB)                          cls = CLS_NONE;
      else if (byte_ff == BYTE_OLDER)                        cls = CLS_OLDER;
      else if (byte_ff == BYTE_NEWER)                        cls = CLS_NEWER;
      else if (byte_ff == BYTE_KILL)                         cls = CLS_KILL;
      else if (byte_ff == BYTE_WORD)                         cls = CLS_WORD;
      else if (byte_ff == BYTE_INTR)                         cls = CLS_CANCEL;
      else if (byte_ff >= BYTE_SPACE && byte_ff <= BYTE_PRINT_HI) cls = CLS_PRINT;
      else                                                   cls = CLS_NONE;
   end

   always_comb begin
      unique case (cmd.ch_sel)
         CH_ZERO: emit_char = '0;
         CH_BYTE: emit_char = byte_ff;
         CH_EDIT: emit_char = edit_rd_ff;
         CH_HIST: emit_char = hist_rd_ff;
         default: emit_char = '0;
      endcase
   end

   assign out_free = !out_v_ff || rsp_ready;

   always_comb begin
      cursor_in   = cursor_ff;
      idx_in      = idx_ff;
      limit_in    = limit_ff;
      head_in     = head_ff;
      browse_in   = browse_ff;
      fill_in     = fill_ff;
      browsing_in = browsing_ff;
      hold_v_in    = hold_v_ff;
      hold_kind_in = hold_kind_ff;
      hold_char_in = hold_char_ff;
      out_v_in     = out_v_ff && !rsp_ready;
      out_kind_in  = out_kind_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (cmd.clear_line)      cursor_in = '0;
      else if (cmd.cursor_inc) cursor_in = cursor_ff + 1'b1;
      else if (cmd.cursor_dec) cursor_in = cursor_ff - 1'b1;

      if (cmd.idx_clr)      idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_ff + 1'b1;

      if (cmd.limit_load) limit_in = hl_rd_ff;

      if (cmd.browse_newest) browse_in = newest;
      else if (cmd.browse_dec)
         browse_in = (browse_ff == '0) ? SLOT_W'(HIST_DEPTH - 1) : browse_ff - 1'b1;
      else if (cmd.browse_inc)
         browse_in = (browse_ff == SLOT_W'(HIST_DEPTH - 1)) ? '0 : browse_ff + 1'b1;

      if (cmd.clear_line || cmd.browsing_clr) browsing_in = 1'b0;
      else if (cmd.browsing_set)              browsing_in = 1'b1;

      if (cmd.commit) begin
         head_in = (head_ff == SLOT_W'(HIST_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         if (fill_ff != FILL_W'(HIST_DEPTH)) fill_in = fill_ff + 1'b1;
      end

      // one token is held back so the last of a run can be marked
      if (cmd.emit) begin
         if (hold_v_ff) begin
            out_v_in    = 1'b1;
            out_kind_in = hold_kind_ff;
            out_char_in = hold_char_ff;
            out_last_in = 1'b0;
         end
         hold_v_in    = 1'b1;
         hold_kind_in = cmd.kind;
         hold_char_in = emit_char;
      end else if (cmd.flush && hold_v_ff && out_free) begin
         out_v_in    = 1'b1;
         out_kind_in = hold_kind_ff;
         out_char_in = hold_char_ff;
         out_last_in = 1'b1;
         hold_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         head_ff     <= '0;
         browse_ff   <= '0;
         fill_ff     <= '0;
         browsing_ff <= 1'b0;
         hold_v_ff   <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         head_ff     <= head_in;
         browse_ff   <= browse_in;
         fill_ff     <= fill_in;
         browsing_ff <= browsing_in;
         hold_v_ff   <= hold_v_in;
         out_v_ff    <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_byte) byte_ff <= rx_byte;
      idx_ff       <= idx_in;
      limit_ff     <= limit_in;
      hold_kind_ff <= hold_kind_in;
      hold_char_ff <= hold_char_in;
      out_kind_ff  <= out_kind_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
   end

   // memories with registered reads
   always_ff @(posedge clock) begin
      if (cmd.edit_wr) edit_mem[cursor_ff] <= edit_wdata;
      edit_rd_ff <= edit_mem[edit_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.hist_wr) hist_mem[hist_waddr] <= edit_rd_ff;
      hist_rd_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) hl_mem[head_ff] <= cursor_ff;
      hl_rd_ff <= hl_mem[hl_raddr];
   end

   always_comb begin
      sts.cls             = cls;
      sts.cursor_zero     = (cursor_ff == '0);
      sts.cursor_full     = (cursor_ff == CUR_W'(LINE_LEN - 1));
      sts.fill_zero       = (fill_ff == '0);
      sts.browsing        = browsing_ff;
      sts.at_oldest       = (browse_ff == oldest);
      sts.at_newest       = (browse_ff == newest);
      sts.idx_last_cursor = (({1'b0, idx_ff} + 1'b1) == {1'b0, cursor_ff});
      sts.idx_last_limit  = (({1'b0, idx_ff} + 1'b1) == {1'b0, limit_ff});
      sts.hl_eq_cursor    = (hl_rd_ff == cursor_ff);
      sts.cmp_eq          = (edit_rd_ff == hist_rd_ff);
      sts.tail_blank      = (edit_rd_ff == BYTE_SPACE) || (edit_rd_ff == BYTE_TAB);
      sts.can_emit        = !hold_v_ff || out_free;
      sts.flush_ok        = !hold_v_ff || out_free;
      sts.hold_empty      = !hold_v_ff;
   end

   assign rsp_valid   = out_v_ff;
   assign token_kind  = out_kind_ff;
   assign token_char  = out_char_ff;
   assign last_of_run = out_last_ff;

endmodule

// ----- rtl/core/tleh_ctrl.sv -----
// sequencer of the line editor: decodes a byte and walks line and history
module tleh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tleh_pkg::tleh_sts_type sts,
   output tleh_pkg::tleh_cmd_type cmd
);
   import tleh_pkg::*;

   typedef enum logic [19:0] {
      S_IDLE    = 20'h00001,
      S_DECODE  = 20'h00002,
      S_ERASE   = 20'h00004,
      S_HL_RD   = 20'h00008,
      S_HL_USE  = 20'h00010,
      S_EC_RD   = 20'h00020,
      S_EC_EMIT = 20'h00040,
      S_LN_RD   = 20'h00080,
      S_LN_EMIT = 20'h00100,
      S_ST_CHK  = 20'h00200,
      S_ST_LEN  = 20'h00400,
      S_CMP_RD  = 20'h00800,
      S_CMP_USE = 20'h01000,
      S_CP_RD   = 20'h02000,
      S_CP_WR   = 20'h04000,
      S_W1_RD   = 20'h08000,
      S_W1_USE  = 20'h10000,
      S_W2_RD   = 20'h20000,
      S_W2_USE  = 20'h40000,
      S_FLUSH   = 20'h80000
   } tleh_state_type;

   tleh_state_type state_ff, state_in;
   logic           echo_ff, echo_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      echo_in  = echo_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_byte = 1'b1;
               state_in       = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.cls)
               CLS_ENTER: begin
                  if (sts.can_emit) begin
                     cmd.emit = 1'b1;
                     cmd.kind = TK_NEWLINE;
                     if (sts.cursor_zero) begin
                        cmd.clear_line = 1'b1;
                        state_in       = S_FLUSH;
                     end else begin
                        cmd.idx_clr = 1'b1;
                        state_in    = S_LN_RD;
                     end
                  end
               end
               CLS_BS: begin
                  if (sts.cursor_zero) state_in = S_FLUSH;
                  else if (sts.can_emit) begin
                     cmd.emit       = 1'b1;
                     cmd.kind       = TK_ERASE;
                     cmd.cursor_dec = 1'b1;
                     state_in       = S_FLUSH;
                  end
               end
               CLS_OLDER: begin
                  if (sts.fill_zero || (sts.browsing && sts.at_oldest)) begin
                     if (sts.can_emit) begin
                        cmd.emit = 1'b1;
                        cmd.kind = TK_BELL;
                        state_in = S_FLUSH;
                     end
                  end else begin
                     if (!sts.browsing) begin
                        cmd.browse_newest = 1'b1;
                        cmd.browsing_set  = 1'b1;
                     end else begin
                        cmd.browse_dec = 1'b1;
                     end
                     echo_in  = 1'b1;
                     state_in = S_ERASE;
                  end
               end
               CLS_NEWER: begin
                  if (sts.fill_zero || !sts.browsing) begin
                     if (sts.can_emit) begin
                        cmd.emit = 1'b1;
                        cmd.kind = TK_BELL;
                        state_in = S_FLUSH;
                     end
                  end else if (sts.at_newest) begin
                     cmd.browsing_clr = 1'b1;
                     echo_in          = 1'b0;
                     state_in         = S_ERASE;
                  end else begin
                     cmd.browse_inc = 1'b1;
                     echo_in        = 1'b1;
                     state_in       = S_ERASE;
                  end
               end
               CLS_KILL: begin
                  echo_in  = 1'b0;
                  state_in = S_ERASE;
               end
               CLS_WORD: state_in = S_W1_RD;
               CLS_CANCEL: begin
                  if (sts.can_emit) begin
                     cmd.emit       = 1'b1;
                     cmd.kind       = TK_CANCEL;
                     cmd.clear_line = 1'b1;
                     state_in       = S_FLUSH;
                  end
               end
               CLS_PRINT: begin
                  if (sts.can_emit) begin
                     cmd.emit = 1'b1;
                     if (sts.cursor_full) begin
                        cmd.kind = TK_BELL;
                     end else begin
                        cmd.kind       = TK_ECHO;
                        cmd.ch_sel     = CH_BYTE;
                        cmd.edit_wr    = 1'b1;
                        cmd.cursor_inc = 1'b1;
                     end
                     state_in = S_FLUSH;
                  end
               end
               CLS_NONE: state_in = S_FLUSH;
               default:  state_in = S_FLUSH;
            endcase
         end
         S_ERASE: begin
            cmd.hl_rd_browse = 1'b1;
            if (!sts.cursor_zero) begin
               if (sts.can_emit) begin
                  cmd.emit       = 1'b1;
                  cmd.kind       = TK_ERASE;
                  cmd.cursor_dec = 1'b1;
               end
            end else if (echo_ff) begin
               state_in = S_HL_RD;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_HL_RD: begin
            cmd.hl_rd_browse = 1'b1;
            state_in         = S_HL_USE;
         end
         S_HL_USE: begin
            cmd.hl_rd_browse = 1'b1;
            cmd.limit_load   = 1'b1;
            cmd.idx_clr      = 1'b1;
            state_in         = S_EC_RD;
         end
         S_EC_RD: begin
            cmd.hist_rd_browse = 1'b1;
            state_in           = S_EC_EMIT;
         end
         S_EC_EMIT: begin
            cmd.hist_rd_browse = 1'b1;
            if (sts.can_emit) begin
               cmd.emit         = 1'b1;
               cmd.kind         = TK_ECHO;
               cmd.ch_sel       = CH_HIST;
               cmd.edit_wr      = 1'b1;
               cmd.edit_wr_hist = 1'b1;
               cmd.cursor_inc   = 1'b1;
               cmd.idx_inc      = 1'b1;
               state_in         = sts.idx_last_limit ? S_FLUSH : S_EC_RD;
            end
         end
         S_LN_RD: state_in = S_LN_EMIT;
         S_LN_EMIT: begin
            if (sts.can_emit) begin
               cmd.emit    = 1'b1;
               cmd.kind    = TK_LINE;
               cmd.ch_sel  = CH_EDIT;
               cmd.idx_inc = 1'b1;
               state_in    = sts.idx_last_cursor ? S_ST_CHK : S_LN_RD;
            end
         end
         S_ST_CHK: begin
            cmd.idx_clr = 1'b1;
            state_in    = sts.fill_zero ? S_CP_RD : S_ST_LEN;
         end
         S_ST_LEN: begin
            cmd.idx_clr = 1'b1;
            state_in    = sts.hl_eq_cursor ? S_CMP_RD : S_CP_RD;
         end
         S_CMP_RD: state_in = S_CMP_USE;
         S_CMP_USE: begin
            if (!sts.cmp_eq) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_CP_RD;
            end else if (sts.idx_last_cursor) begin
               cmd.clear_line = 1'b1;
               state_in       = S_FLUSH;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_CMP_RD;
            end
         end
         S_CP_RD: state_in = S_CP_WR;
         S_CP_WR: begin
            cmd.hist_wr = 1'b1;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last_cursor) begin
               cmd.commit     = 1'b1;
               cmd.clear_line = 1'b1;
               state_in       = S_FLUSH;
            end else begin
               state_in = S_CP_RD;
            end
         end
         S_W1_RD: begin
            cmd.edit_rd_tail = 1'b1;
            state_in         = sts.cursor_zero ? S_FLUSH : S_W1_USE;
         end
         S_W1_USE: begin
            cmd.edit_rd_tail = 1'b1;
            if (!sts.tail_blank) state_in = S_W2_RD;
            else if (sts.can_emit) begin
               cmd.emit       = 1'b1;
               cmd.kind       = TK_ERASE;
               cmd.cursor_dec = 1'b1;
               state_in       = S_W1_RD;
            end
         end
         S_W2_RD: begin
            cmd.edit_rd_tail = 1'b1;
            state_in         = sts.cursor_zero ? S_FLUSH : S_W2_USE;
         end
         S_W2_USE: begin
            cmd.edit_rd_tail = 1'b1;
            if (sts.tail_blank) state_in = S_FLUSH;
            else if (sts.can_emit) begin
               cmd.emit       = 1'b1;
               cmd.kind       = TK_ERASE;
               cmd.cursor_dec = 1'b1;
               state_in       = S_W2_RD;
            end
         end
         S_FLUSH: begin
            cmd.flush = 1'b1;
            if (sts.flush_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         echo_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         echo_ff  <= echo_in;
      end
   end

endmodule

// ----- rtl/core/terminal_line_editor_history_unit.sv -----
// top level of the terminal line editor with history ring
// The block takes one received terminal byte per request beat and answers with a run of
// token beats (echo, erase, bell, newline, cancel, committed line chars), the last beat of
// each run flagged by last_of_run; bytes that cause nothing give no beat at all. Bytes are
// handled one at a time: a new request is taken only once every token of the previous byte
// has left the internal hold stage. Single-key edits go from accept through decode and
// flush back to idle. Anything that walks the line goes through the edit-line and history
// memories, whose read ports are registered, so each character takes a read state and a
// use state. Ctrl-U and the erase ahead of a recall run one erase per cycle while the
// response port accepts; Ctrl-W reads and tests each char in turn, history recall erases
// the line then reads and echoes each char of the entry, and Enter emits the line, compares
// it with the newest entry and copies it into the ring unless it equals that entry. No
// clearing pass is needed after reset; history slots are only read once filled. A stalled
// response port holds the sequencer at the next token.
module terminal_line_editor_history_unit #(
   parameter int LINE_LEN   = 32,
   parameter int HIST_DEPTH = 8
) (
   input logic       clock,
   input logic       reset,
   tleh_req_if.sink  req_ch,
   tleh_rsp_if.source rsp_ch
);
   import tleh_pkg::*;

   // command and status between sequencer and datapath
   tleh_cmd_type cmd;
   tleh_sts_type sts;

   // sequencer: byte decode and per-character walks
   tleh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: line, ring, token hold and response register
   tleh_dp #(
      .LINE_LEN   (LINE_LEN),
      .HIST_DEPTH (HIST_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .rx_byte     (req_ch.rx_byte),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_ch.valid),
      .token_kind  (rsp_ch.token_kind),
      .token_char  (rsp_ch.token_char),
      .last_of_run (rsp_ch.last_of_run)
   );

`include "assert_macros.svh"

   // the hold stage is empty whenever a new byte can be taken
   `TLEH_ASSERT_NOW(a_idle_hold_empty, clock, reset, req_ch.ready, sts.hold_empty)
   // one byte at a time
   `TLEH_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   // browsing only ever happens with a non-empty ring
   `TLEH_ASSERT_NOW(a_browse_needs_ring, clock, reset, sts.fill_zero, !sts.browsing)

endmodule
